// File: src/rcic_pkg.sv
// Shared types and constants for the radio channel index converter.
// Holds band tables, request codes and the inter-stage structs; no dependencies.
package rcic_pkg;

  localparam logic [1:0] ACT_IDX_TO_KHZ = 2'd0;
  localparam logic [1:0] ACT_KHZ_TO_IDX = 2'd1;
  localparam logic [1:0] ACT_COUNT      = 2'd2;

  localparam logic [1:0] BAND_COM_FINE = 2'd0;
  localparam logic [1:0] BAND_COM_25   = 2'd1;
  localparam logic [1:0] BAND_NAV      = 2'd2;

  localparam int unsigned ValueW = 18;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned BaseW  = 17;
  localparam int unsigned SpaceW = 7;
  localparam int unsigned RecipW = 20;
  localparam int unsigned RecipSh = 24;
  localparam int unsigned QuotW  = 13;
  localparam int unsigned RemW   = 8;
  localparam int unsigned CountW = 12;

  localparam logic [BaseW-1:0] BASE_COM = 17'd118000;
  localparam logic [BaseW-1:0] BASE_NAV = 17'd108000;

  localparam logic [SpaceW-1:0] SPACE_FINE = 7'd100;
  localparam logic [SpaceW-1:0] SPACE_25   = 7'd25;
  localparam logic [SpaceW-1:0] SPACE_NAV  = 7'd50;

  // floor(2^24 / spacing); quotient estimate is at most one low
  localparam logic [RecipW-1:0] RECIP_FINE = 20'd167772;
  localparam logic [RecipW-1:0] RECIP_25   = 20'd671088;
  localparam logic [RecipW-1:0] RECIP_NAV  = 20'd335544;

  localparam logic [CountW-1:0] COUNT_FINE = 12'd3040;
  localparam logic [CountW-1:0] COUNT_25   = 12'd760;
  localparam logic [CountW-1:0] COUNT_NAV  = 12'd200;

  localparam logic [SpaceW-1:0] FINE_OFFSET [16] = '{
    7'd0, 7'd5, 7'd10, 7'd15, 7'd25, 7'd30, 7'd35, 7'd40,
    7'd50, 7'd55, 7'd60, 7'd65, 7'd75, 7'd80, 7'd85, 7'd90
  };

  typedef enum logic [1:0] {
    KIND_IDX = 2'd0,
    KIND_KHZ = 2'd1,
    KIND_CNT = 2'd2,
    KIND_BAD = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               fine;
    logic [ValueW-1:0]  r;
    logic [IdxW-1:0]    step;
    logic [SpaceW-1:0]  spacing;
    logic [SpaceW-1:0]  off;
    logic [BaseW-1:0]   base;
    logic [RecipW-1:0]  recip;
    logic [CountW-1:0]  count;
  } s1_t;

  typedef struct packed {
    kind_e              kind;
    logic               fine;
    logic [ValueW-1:0]  r;
    logic [QuotW-1:0]   q0;
    logic [SpaceW-1:0]  spacing;
    logic [ValueW-1:0]  idx_khz;
    logic [CountW-1:0]  count;
  } s2_t;

  typedef struct packed {
    kind_e              kind;
    logic               fine;
    logic [QuotW-1:0]   q0;
    logic [RemW-1:0]    rem0;
    logic [SpaceW-1:0]  spacing;
    logic [ValueW-1:0]  idx_khz;
    logic [CountW-1:0]  count;
  } s3_t;

endpackage

// File: src/rcic_decode.sv
// First pipeline stage: decodes band and action, subtracts the band base.
// Depends on rcic_pkg.
module rcic_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [1:0]                 band_i,
  input  logic [rcic_pkg::IdxW-1:0]  channel_index_i,
  input  logic [rcic_pkg::ValueW-1:0] freq_khz_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rcic_pkg::s1_t              out_o
);

  rcic_pkg::s1_t data_d, data_q;
  logic          valid_q;
  logic          band_ok;
  logic          below;

  always_comb begin
    data_d         = '0;
    band_ok        = 1'b1;
    data_d.fine    = (band_i == rcic_pkg::BAND_COM_FINE);
    case (band_i)
      rcic_pkg::BAND_COM_FINE: begin
        data_d.base    = rcic_pkg::BASE_COM;
        data_d.spacing = rcic_pkg::SPACE_FINE;
        data_d.recip   = rcic_pkg::RECIP_FINE;
        data_d.count   = rcic_pkg::COUNT_FINE;
      end
      rcic_pkg::BAND_COM_25: begin
        data_d.base    = rcic_pkg::BASE_COM;
        data_d.spacing = rcic_pkg::SPACE_25;
        data_d.recip   = rcic_pkg::RECIP_25;
        data_d.count   = rcic_pkg::COUNT_25;
      end
      rcic_pkg::BAND_NAV: begin
        data_d.base    = rcic_pkg::BASE_NAV;
        data_d.spacing = rcic_pkg::SPACE_NAV;
        data_d.recip   = rcic_pkg::RECIP_NAV;
        data_d.count   = rcic_pkg::COUNT_NAV;
      end
      default: band_ok = 1'b0;
    endcase

    below    = (freq_khz_i < {1'b0, data_d.base});
    data_d.r = freq_khz_i - {1'b0, data_d.base};

    if (data_d.fine) begin
      data_d.step = {4'b0, channel_index_i[rcic_pkg::IdxW-1:4]};
      data_d.off  = rcic_pkg::FINE_OFFSET[channel_index_i[3:0]];
    end else begin
      data_d.step = channel_index_i;
      data_d.off  = '0;
    end

    case (action_i)
      rcic_pkg::ACT_IDX_TO_KHZ: data_d.kind = rcic_pkg::KIND_IDX;
      rcic_pkg::ACT_KHZ_TO_IDX: data_d.kind = below ? rcic_pkg::KIND_BAD : rcic_pkg::KIND_KHZ;
      rcic_pkg::ACT_COUNT:      data_d.kind = rcic_pkg::KIND_CNT;
      default:                  data_d.kind = rcic_pkg::KIND_BAD;
    endcase
    if (!band_ok) begin
      data_d.kind = rcic_pkg::KIND_BAD;
    end
  end

  assign in_stall_o  = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: src/rcic_mult.sv
// Second pipeline stage: reciprocal multiply for the quotient estimate and
// index-to-kHz scaling. Depends on rcic_pkg.
module rcic_mult (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rcic_pkg::s1_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rcic_pkg::s2_t  out_o
);

  localparam int unsigned ProdW = rcic_pkg::ValueW + rcic_pkg::RecipW;

  rcic_pkg::s2_t    data_d, data_q;
  logic             valid_q;
  logic [ProdW-1:0] prod;
  logic [19:0]      khz_sum;

  always_comb begin
    prod    = ProdW'(in_i.r) * ProdW'(in_i.recip);
    khz_sum = 20'(in_i.step) * 20'(in_i.spacing) + 20'(in_i.base) + 20'(in_i.off);

    data_d         = '0;
    data_d.kind    = in_i.kind;
    data_d.fine    = in_i.fine;
    data_d.r       = in_i.r;
    data_d.q0      = prod[rcic_pkg::RecipSh +: rcic_pkg::QuotW];
    data_d.spacing = in_i.spacing;
    data_d.idx_khz = khz_sum[rcic_pkg::ValueW-1:0];
    data_d.count   = in_i.count;
  end

  assign in_stall_o  = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: src/rcic_remain.sv
// Third pipeline stage: back-multiplies the quotient estimate and forms the
// uncorrected remainder. Depends on rcic_pkg.
module rcic_remain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rcic_pkg::s2_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rcic_pkg::s3_t  out_o
);

  rcic_pkg::s3_t               data_d, data_q;
  logic                        valid_q;
  logic [19:0]                 back;
  logic [rcic_pkg::ValueW-1:0] diff;

  always_comb begin
    back = 20'(in_i.q0) * 20'(in_i.spacing);
    diff = in_i.r - back[rcic_pkg::ValueW-1:0];

    data_d         = '0;
    data_d.kind    = in_i.kind;
    data_d.fine    = in_i.fine;
    data_d.q0      = in_i.q0;
    data_d.rem0    = diff[rcic_pkg::RemW-1:0];
    data_d.spacing = in_i.spacing;
    data_d.idx_khz = in_i.idx_khz;
    data_d.count   = in_i.count;
  end

  assign in_stall_o  = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: src/rcic_resolve.sv
// Last pipeline stage: corrects the quotient, finds the fine sub-step and
// registers the result. Depends on rcic_pkg.
module rcic_resolve (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rcic_pkg::s3_t               in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rcic_pkg::ValueW-1:0] value_o,
  output logic                        bad_request_o
);

  logic                         valid_q;
  logic [rcic_pkg::ValueW-1:0]  value_d, value_q;
  logic                         bad_d, bad_q;
  logic                         ge;
  logic [rcic_pkg::QuotW-1:0]   quot;
  logic [rcic_pkg::RemW-1:0]    rem_w;
  logic [rcic_pkg::SpaceW-1:0]  rem;
  logic [4:0]                   sub;
  logic [rcic_pkg::ValueW-1:0]  khz_idx;

  always_comb begin
    ge    = (in_i.rem0 >= {1'b0, in_i.spacing});
    quot  = in_i.q0 + rcic_pkg::QuotW'(ge);
    rem_w = ge ? (in_i.rem0 - {1'b0, in_i.spacing}) : in_i.rem0;
    rem   = rem_w[rcic_pkg::SpaceW-1:0];

    sub = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (rcic_pkg::FINE_OFFSET[i] >= rem) begin
        sub = 5'(i);
      end
    end

    if (in_i.fine) begin
      khz_idx = {1'b0, quot, 4'b0} + rcic_pkg::ValueW'(sub);
    end else begin
      khz_idx = rcic_pkg::ValueW'(quot);
    end

    bad_d = 1'b0;
    case (in_i.kind)
      rcic_pkg::KIND_IDX: value_d = in_i.idx_khz;
      rcic_pkg::KIND_KHZ: value_d = khz_idx;
      rcic_pkg::KIND_CNT: value_d = rcic_pkg::ValueW'(in_i.count);
      default: begin
        value_d = '0;
        bad_d   = 1'b1;
      end
    endcase
  end

  assign in_stall_o    = valid_q && out_stall_i;
  assign out_valid_o   = valid_q;
  assign value_o       = value_q;
  assign bad_request_o = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      value_q <= value_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// File: src/radio_channel_index_converter_core.sv
// Radio channel index converter: turns channel indices into kHz, kHz into
// channel indices, or reports channel counts for the COM fine-step, COM 25 kHz
// and NAV bands. One request enters per cycle unless in_stall_o is raised; each
// request passes through the four-stage pipeline (decode, reciprocal multiply,
// remainder, correction and sub-step search). Division by the channel spacing
// uses a fixed reciprocal multiply with a single correction step. A stall on
// the output holds every full stage back to the first empty one.
// Depends on rcic_pkg and the rcic stage modules.
module radio_channel_index_converter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [1:0]                  band_i,
  input  logic [rcic_pkg::IdxW-1:0]   channel_index_i,
  input  logic [rcic_pkg::ValueW-1:0] freq_khz_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rcic_pkg::ValueW-1:0] value_o,
  output logic                        bad_request_o
);

  rcic_pkg::s1_t s1;
  rcic_pkg::s2_t s2;
  rcic_pkg::s3_t s3;
  logic          s1_valid, s2_valid, s3_valid;
  logic          s1_stall, s2_stall, s3_stall;

  rcic_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .band_i          (band_i),
    .channel_index_i (channel_index_i),
    .freq_khz_i      (freq_khz_i),
    .out_valid_o     (s1_valid),
    .out_stall_i     (s1_stall),
    .out_o           (s1)
  );

  rcic_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_stall_o  (s1_stall),
    .in_i        (s1),
    .out_valid_o (s2_valid),
    .out_stall_i (s2_stall),
    .out_o       (s2)
  );

  rcic_remain u_remain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_stall_o  (s2_stall),
    .in_i        (s2),
    .out_valid_o (s3_valid),
    .out_stall_i (s3_stall),
    .out_o       (s3)
  );

  rcic_resolve u_resolve (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s3_valid),
    .in_stall_o    (s3_stall),
    .in_i          (s3),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .bad_request_o (bad_request_o)
  );

endmodule
